@@ rtl/core/pblru_pkg.sv @@
// Package: constants, status codes and widths for the page buffer LRU pin manager.
`timescale 1ns / 1ps
package pblru_pkg;
   localparam int FRAMES_DEF   = 64;
   localparam int PIN_BITS_DEF = 8;
   localparam int PAGE_W       = 64;
   localparam int FIDX_W       = 6;
   localparam int LIMIT_W      = 7;
   localparam int STATUS_W     = 3;

   localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISS_FREE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISS_EVCT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_FRAME  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNFIXED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_UNFIX_ERR = 3'd5;
   localparam logic [STATUS_W-1:0] ST_PIN_OVF   = 3'd6;

   localparam logic OP_FIX   = 1'b0;
   localparam logic OP_UNFIX = 1'b1;

   typedef struct packed {
      logic                op;
      logic [PAGE_W-1:0]   page_id;
      logic [FIDX_W-1:0]   frame_index;
      logic                mark_dirty;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIDX_W-1:0]   frame_slot;
      logic [PAGE_W-1:0]   victim_page;
      logic                victim_dirty;
   } rsp_type;
endpackage

@@ rtl/core/pblru_if.sv @@
// Interfaces: request, response and register write channels.
`timescale 1ns / 1ps
interface pblru_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [63:0]                page_id;
   logic [5:0]                 frame_index;
   logic                       mark_dirty;
   modport source (output valid, op, page_id, frame_index, mark_dirty, input ready);
   modport sink   (input valid, op, page_id, frame_index, mark_dirty, output ready);
endinterface

interface pblru_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [2:0]                 status;
   logic [5:0]                 frame_slot;
   logic [63:0]                victim_page;
   logic                       victim_dirty;
   modport source (output valid, status, frame_slot, victim_page, victim_dirty, input ready);
   modport sink   (input valid, status, frame_slot, victim_page, victim_dirty, output ready);
endinterface

interface pblru_csr_if;
   logic                       valid;
   logic                       ready;
   logic [6:0]                 data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/pblru_core.sv @@
// Core: frame table, LRU list, tag match and one-pass update per request word.
`timescale 1ns / 1ps
module pblru_core #(
   parameter int FRAMES   = pblru_pkg::FRAMES_DEF,
   parameter int PIN_BITS = pblru_pkg::PIN_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  pblru_pkg::req_type                   req,
   input  logic [pblru_pkg::LIMIT_W-1:0]        limit_raw,
   output pblru_pkg::rsp_type                   rsp
);
   import pblru_pkg::*;
   localparam int SW = $clog2(FRAMES);
   localparam int LW = SW + 1;   // room for the null marker
   localparam logic [LW-1:0] NIL = LW'(FRAMES);
   localparam logic [PIN_BITS-1:0] PMAX = '1;

   logic [PAGE_W-1:0]   tag_ff   [FRAMES];
   logic [PIN_BITS-1:0] pins_ff  [FRAMES], pins_in  [FRAMES];
   logic                dirty_ff [FRAMES], dirty_in [FRAMES];
   logic [LW-1:0]       next_ff  [FRAMES], next_in  [FRAMES];
   logic [LW-1:0]       prev_ff  [FRAMES], prev_in  [FRAMES];
   logic [LW-1:0]       old_ff, old_in, new_ff, new_in, fill_ff, fill_in;
   logic                tag_we;
   logic [SW-1:0]       tag_wa;

   logic [FRAMES-1:0]   match;
   logic                hit;
   logic [SW-1:0]       hit_s;
   logic [LW-1:0]       limit;
   logic [LW-1:0]       uidx;

   always_comb begin
      match = '0;
      for (int i = 0; i < FRAMES; i++)
         match[i] = (LW'(i) < fill_ff) && (tag_ff[i] == req.page_id);
      hit = |match;
      hit_s = '0;
      for (int i = FRAMES - 1; i >= 0; i--)
         if (match[i]) hit_s = SW'(i);
      if (limit_raw == '0) limit = LW'(1);
      else if (32'(limit_raw) > FRAMES) limit = NIL;
      else limit = LW'(limit_raw);
      uidx = LW'(req.frame_index);
   end

   // resolve the request, then unlink or append s in the list; applied to the _in copies
   always_comb begin
      logic [LW-1:0] p, n;
      logic [SW-1:0] s;
      logic          do_unlink, do_append;
      for (int i = 0; i < FRAMES; i++) begin
         pins_in[i] = pins_ff[i]; dirty_in[i] = dirty_ff[i];
         next_in[i] = next_ff[i]; prev_in[i] = prev_ff[i];
      end
      old_in = old_ff; new_in = new_ff; fill_in = fill_ff;
      tag_we = 1'b0; tag_wa = '0;
      rsp = '0;
      s = '0; do_unlink = 1'b0; do_append = 1'b0;
      p = NIL; n = NIL;
      if (req.op == OP_FIX) begin
         if (hit) begin
            rsp.frame_slot = FIDX_W'(hit_s);
            if (pins_ff[hit_s] == PMAX) rsp.status = ST_PIN_OVF;
            else begin
               rsp.status = ST_HIT;
               s = hit_s;
               do_unlink = (pins_ff[hit_s] == '0);
               pins_in[hit_s] = pins_ff[hit_s] + 1'b1;
            end
         end else if (fill_ff < limit) begin
            s = fill_ff[SW-1:0];
            tag_we = 1'b1; tag_wa = s;
            pins_in[s] = PIN_BITS'(1); dirty_in[s] = 1'b0;
            next_in[s] = NIL; prev_in[s] = NIL;
            fill_in = fill_ff + 1'b1;
            rsp.status = ST_MISS_FREE; rsp.frame_slot = FIDX_W'(s);
         end else if (old_ff != NIL) begin
            s = old_ff[SW-1:0];
            rsp.victim_page = tag_ff[s]; rsp.victim_dirty = dirty_ff[s];
            do_unlink = 1'b1;
            tag_we = 1'b1; tag_wa = s;
            pins_in[s] = PIN_BITS'(1); dirty_in[s] = 1'b0;
            rsp.status = ST_MISS_EVCT; rsp.frame_slot = FIDX_W'(s);
         end else rsp.status = ST_NO_FRAME;
      end else begin
         rsp.frame_slot = req.frame_index;
         if (32'(req.frame_index) >= FRAMES || uidx >= fill_ff ||
             pins_ff[uidx[SW-1:0]] == '0) rsp.status = ST_UNFIX_ERR;
         else begin
            s = uidx[SW-1:0];
            rsp.status = ST_UNFIXED;
            if (req.mark_dirty) dirty_in[s] = 1'b1;
            pins_in[s] = pins_ff[s] - 1'b1;
            do_append = (pins_ff[s] == PIN_BITS'(1));
         end
      end
      if (do_unlink) begin
         p = prev_ff[s]; n = next_ff[s];
         if (p != NIL) next_in[p[SW-1:0]] = n;
         if (n != NIL) prev_in[n[SW-1:0]] = p;
         if (old_ff == LW'(s)) old_in = n;
         if (new_ff == LW'(s)) new_in = p;
         next_in[s] = NIL; prev_in[s] = NIL;
      end
      if (do_append) begin
         next_in[s] = NIL; prev_in[s] = new_ff;
         if (new_ff != NIL) next_in[new_ff[SW-1:0]] = LW'(s);
         else old_in = LW'(s);
         new_in = LW'(s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            pins_ff[i] <= '0; dirty_ff[i] <= 1'b0;
            next_ff[i] <= NIL; prev_ff[i] <= NIL;
         end
         old_ff <= NIL; new_ff <= NIL; fill_ff <= '0;
      end else if (go) begin
         for (int i = 0; i < FRAMES; i++) begin
            pins_ff[i] <= pins_in[i]; dirty_ff[i] <= dirty_in[i];
            next_ff[i] <= next_in[i]; prev_ff[i] <= prev_in[i];
         end
         old_ff <= old_in; new_ff <= new_in; fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && tag_we) tag_ff[tag_wa] <= req.page_id;
   end
endmodule

@@ rtl/core/page_buffer_lru_pin_manager.sv @@
// Top level: page buffer LRU pin manager with request/response and register ports.
`timescale 1ns / 1ps
// Fully associative page buffer with pin counts and LRU replacement. Each
// request word (fix a page id, or unfix a frame) is registered on accept and
// resolved by a single pass over the frame table: parallel tag compare, pin
// update and constant-time LRU list relink. One response word per request;
// one request accepted per cycle unless the request side stalls, the rate set
// by the single frame-table update per cycle. A one-deep response register
// holds a result while rsp_ready is low; the request side stalls only when
// the response register is full and not being drained. Write frames_in_use on
// the csr port only while idle; 0 acts as 1, values above FRAMES act as FRAMES.
module page_buffer_lru_pin_manager #(
   parameter int FRAMES   = pblru_pkg::FRAMES_DEF,
   parameter int PIN_BITS = pblru_pkg::PIN_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   pblru_req_if.sink  req,
   pblru_rsp_if.source rsp,
   pblru_csr_if.sink  csr
);
   import pblru_pkg::*;

   req_type                 rq_ff;
   logic                    rqv_ff;
   rsp_type                 rs_ff, core_rsp;
   logic                    rsv_ff;
   logic [LIMIT_W-1:0]      lim_ff;
   logic                    go, out_free;

   // stage advances when the response slot is empty or draining
   assign out_free  = !rsv_ff || rsp.ready;
   assign go        = rqv_ff && out_free;
   assign req.ready = !rqv_ff || out_free;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) lim_ff <= LIMIT_W'(64);
      else if (csr.valid) lim_ff <= csr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rqv_ff <= 1'b0; rsv_ff <= 1'b0;
      end else begin
         if (req.ready) rqv_ff <= req.valid;
         if (out_free) rsv_ff <= go;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready)
         rq_ff <= '{op: req.op, page_id: req.page_id,
                    frame_index: req.frame_index, mark_dirty: req.mark_dirty};
      if (go) rs_ff <= core_rsp;
   end

   pblru_core #(.FRAMES(FRAMES), .PIN_BITS(PIN_BITS)) u_core (
      .clock(clock), .reset(reset), .go(go), .req(rq_ff),
      .limit_raw(lim_ff), .rsp(core_rsp));

   assign rsp.valid        = rsv_ff;
   assign rsp.status       = rs_ff.status;
   assign rsp.frame_slot   = rs_ff.frame_slot;
   assign rsp.victim_page  = rs_ff.victim_page;
   assign rsp.victim_dirty = rs_ff.victim_dirty;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsv_ff && !rsp.ready |=> rsv_ff && $stable(rs_ff)) else $error("rsp lost");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rqv_ff && !go |=> rqv_ff) else $error("request dropped");
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsv_ff |-> rs_ff.status != 3'd7) else $error("bad status");
endmodule
